// ===== sv/pet_pkg.sv =====
package pet_pkg;

   localparam int ELEMENTS_DEF = 64;
   localparam int COLUMNS_DEF  = 7;

   localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [63:0] value;
      logic        ovf;
   } sat_type;

   // handshake between the sequencer and an arithmetic unit
   typedef struct packed {
      logic        done;
      logic        fault;
      logic [63:0] result;
   } unit_rsp_type;

   function automatic sat_type sat_add(logic [63:0] a, logic [63:0] b);
      sat_type r;
      r.value = a + b;
      r.ovf   = (a[63] == b[63]) && (r.value[63] != a[63]);
      if (r.ovf) begin
         r.value = a[63] ? SMIN : SMAX;
      end
      return r;
   endfunction

   function automatic sat_type sat_sub(logic [63:0] a, logic [63:0] b);
      sat_type r;
      r.value = a - b;
      r.ovf   = (a[63] != b[63]) && (r.value[63] != a[63]);
      if (r.ovf) begin
         r.value = a[63] ? SMIN : SMAX;
      end
      return r;
   endfunction

endpackage

// ===== sv/pet_if.sv =====
interface pet_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         est_index;
   logic [62:0]        step_sq;
   logic [5:0]         elem_index;
   logic signed [63:0] sample_value;

   modport source (output valid, est_index, step_sq, elem_index, sample_value, input ready);
   modport sink   (input valid, est_index, step_sq, elem_index, sample_value, output ready);
endinterface

interface pet_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] extrapolated;
   logic signed [63:0] error_estimate;
   logic               fault;

   modport source (output valid, extrapolated, error_estimate, fault, input ready);
   modport sink   (input valid, extrapolated, error_estimate, fault, output ready);
endinterface

// ===== sv/pet_div.sv =====
module pet_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [62:0]           num,
   input  logic [62:0]           den_mag,
   input  logic                  den_neg,
   output pet_pkg::unit_rsp_type rsp
);
   import pet_pkg::*;

   logic        busy_ff, fin_ff, done_ff, flt_ff, over_ff, neg_ff;
   logic [6:0]  cnt_ff;
   logic [95:0] dvd_ff;
   logic [62:0] rem_ff, dm_ff;
   logic [63:0] q_ff, quot_ff;
   logic [63:0] trial;
   logic        take;

   // one quotient bit per cycle while busy
   assign trial = {rem_ff, dvd_ff[95]};
   assign take  = trial >= {1'b0, dm_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            dm_ff  <= den_mag;
            neg_ff <= den_neg;
            dvd_ff <= {1'b0, num, 32'd0};
            rem_ff <= '0;
            q_ff   <= '0;
            over_ff <= 1'b0;
            cnt_ff <= '0;
            if (den_mag == '0) begin
               quot_ff <= SMAX;
               flt_ff  <= 1'b1;
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            rem_ff  <= take ? 63'(trial - {1'b0, dm_ff}) : trial[62:0];
            over_ff <= over_ff | q_ff[63];
            q_ff    <= {q_ff[62:0], take};
            dvd_ff  <= {dvd_ff[94:0], 1'b0};
            cnt_ff  <= cnt_ff + 7'd1;
            if (cnt_ff == 7'd95) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            fin_ff  <= 1'b0;
            done_ff <= 1'b1;
            if (neg_ff) begin
               flt_ff  <= over_ff || (q_ff > SMIN);
               quot_ff <= (over_ff || (q_ff > SMIN)) ? SMIN : (64'd0 - q_ff);
            end else begin
               flt_ff  <= over_ff || q_ff[63];
               quot_ff <= (over_ff || q_ff[63]) ? SMAX : q_ff;
            end
         end
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.fault  = flt_ff;
   assign rsp.result = quot_ff;

endmodule

// ===== sv/pet_mul.sv =====
module pet_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [63:0]           op_a,
   input  logic [63:0]           op_b,
   output pet_pkg::unit_rsp_type rsp
);
   import pet_pkg::*;

   logic         busy_ff, done_ff, neg_ff, flt_ff;
   logic [2:0]   cnt_ff;
   logic [63:0]  a_ff, b_ff, prod_ff;
   logic [63:0]  pp_ff;
   logic [127:0] acc_ff;
   logic         ovf;

   // floor of the product shifted by 32 must fit in 64 signed bits
   assign ovf = (acc_ff[127:96] != {32{acc_ff[95]}});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            a_ff    <= op_a;
            b_ff    <= op_b;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            unique case (cnt_ff)
               3'd0: begin
                  neg_ff <= a_ff[63] ^ b_ff[63];
                  a_ff   <= a_ff[63] ? (64'd0 - a_ff) : a_ff;
                  b_ff   <= b_ff[63] ? (64'd0 - b_ff) : b_ff;
               end
               3'd1: pp_ff <= 64'(a_ff[31:0] * b_ff[31:0]);
               3'd2: begin
                  acc_ff <= {64'd0, pp_ff};
                  pp_ff  <= 64'(a_ff[31:0] * b_ff[63:32]);
               end
               3'd3: begin
                  acc_ff <= acc_ff + {32'd0, pp_ff, 32'd0};
                  pp_ff  <= 64'(a_ff[63:32] * b_ff[31:0]);
               end
               3'd4: begin
                  acc_ff <= acc_ff + {32'd0, pp_ff, 32'd0};
                  pp_ff  <= 64'(a_ff[63:32] * b_ff[63:32]);
               end
               3'd5: acc_ff <= acc_ff + {pp_ff, 64'd0};
               3'd6: acc_ff <= neg_ff ? (128'd0 - acc_ff) : acc_ff;
               3'd7: begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
                  flt_ff  <= ovf;
                  prod_ff <= ovf ? (neg_ff ? SMIN : SMAX) : acc_ff[95:32];
               end
               default: ;
            endcase
         end
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.fault  = flt_ff;
   assign rsp.result = prod_ff;

endmodule

// ===== sv/polynomial_extrapolation_tableau_top.sv =====
// Polynomial extrapolation to zero step size, Neville tableau form.
// req_chan carries one vector element of one estimate: estimate index,
// squared substep (unsigned Q31.32), element index and value (Q32.32).
// rsp_chan returns one transaction per request: extrapolated value, error
// estimate (last correction) and a fault flag for division by zero or
// saturation. Estimates of a sequence must arrive in index order.
// One request is processed at a time; req_chan.ready is high only while
// the sequencer is idle. For estimate n the result is formed column by
// column over the n earlier columns: each runs two bit-serial divisions
// (96 steps, skipped on a zero divisor) and two 32x32-based multiplies on
// the shared units, plus a tableau read, a difference and an accumulate
// step. An out-of-range index skips the tableau and reports a fault.
// The result sits in an output register; a new request is accepted while
// it waits, and the next result is held until rsp_chan.ready frees it.
// Reset is synchronous and clears control state only; the step table and
// tableau memory are undefined until written by in-order estimates.
module polynomial_extrapolation_tableau_top #(
   parameter int ELEMENTS = pet_pkg::ELEMENTS_DEF,
   parameter int COLUMNS  = pet_pkg::COLUMNS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   pet_req_if.sink   req_chan,
   pet_rsp_if.source rsp_chan
);
   import pet_pkg::*;

   localparam int DEPTH = ELEMENTS * COLUMNS;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = $clog2(COLUMNS);

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_READ = 9'b000000010,
      S_DIV1 = 9'b000000100,
      S_DIV2 = 9'b000001000,
      S_DIFF = 9'b000010000,
      S_MUL1 = 9'b000100000,
      S_MUL2 = 9'b001000000,
      S_NEXT = 9'b010000000,
      S_LAST = 9'b100000000
   } state_type;

   state_type   state_ff, state_in;
   logic        pend_ff;
   logic [2:0]  est_ff, k_ff;
   logic [62:0] s_ff, prev_ff;
   logic [AW-1:0] base_ff, addr;
   logic [63:0] yz_ff, dy_ff, c_ff, f1_ff, f2_ff, diff_ff, rd_ff;
   logic        fault_ff;
   logic        rsp_valid_ff;
   logic [63:0] rsp_x_ff, rsp_e_ff;
   logic        rsp_f_ff;

   logic [62:0] step_table [COLUMNS];
   logic [63:0] tab_mem [DEPTH];

   logic        accept, bad, tab_we, tab_re, div_start, mul_start, out_free;
   logic [62:0] prev_rd, div_num, dm;
   logic [63:0] den, tab_wd, mul_b;
   sat_type     diff_s, yz_s;
   unit_rsp_type div_rsp, mul_rsp;

   assign accept   = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && !pend_ff;
   assign bad      = (32'(req_chan.est_index) >= COLUMNS) ||
                     (32'(req_chan.elem_index) >= ELEMENTS);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign prev_rd = step_table[SW'(3'(est_ff - k_ff - 3'd1))];
   assign den     = {1'b0, prev_rd} - {1'b0, s_ff};
   assign dm      = den[63] ? 63'(64'd0 - den) : den[62:0];
   assign addr    = base_ff + AW'(k_ff);
   assign diff_s  = sat_sub(c_ff, rd_ff);
   assign yz_s    = sat_add(yz_ff, dy_ff);

   assign tab_re    = (state_ff == S_READ);
   assign tab_we    = (state_ff == S_DIFF) || (state_ff == S_LAST);
   assign tab_wd    = dy_ff;
   assign div_start = (state_ff == S_READ) || ((state_ff == S_DIV1) && div_rsp.done);
   assign div_num   = (state_ff == S_READ) ? s_ff : prev_ff;
   assign mul_start = (state_ff == S_DIFF) || ((state_ff == S_MUL1) && mul_rsp.done);
   assign mul_b     = (state_ff == S_DIFF) ? diff_s.value : diff_ff;

   pet_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (div_num),
      .den_mag (dm),
      .den_neg (den[63]),
      .rsp     (div_rsp)
   );

   pet_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  ((state_ff == S_DIFF) ? f1_ff : f2_ff),
      .op_b  (mul_b),
      .rsp   (mul_rsp)
   );

   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_mem[addr] <= tab_wd;
      end
      if (tab_re) begin
         rd_ff <= tab_mem[addr];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept && !bad) begin
            state_in = (req_chan.est_index == 3'd0) ? S_LAST : S_READ;
         end
         S_READ: state_in = S_DIV1;
         S_DIV1: if (div_rsp.done) state_in = S_DIV2;
         S_DIV2: if (div_rsp.done) state_in = S_DIFF;
         S_DIFF: state_in = S_MUL1;
         S_MUL1: if (mul_rsp.done) state_in = S_MUL2;
         S_MUL2: if (mul_rsp.done) state_in = S_NEXT;
         S_NEXT: state_in = (3'(k_ff + 3'd1) == est_ff) ? S_LAST : S_READ;
         S_LAST: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            est_ff   <= req_chan.est_index;
            s_ff     <= req_chan.step_sq;
            base_ff  <= AW'(32'(req_chan.elem_index) * COLUMNS);
            k_ff     <= '0;
            yz_ff    <= req_chan.sample_value;
            dy_ff    <= req_chan.sample_value;
            c_ff     <= req_chan.sample_value;
            fault_ff <= bad;
            pend_ff  <= bad;
            if (!bad) begin
               step_table[SW'(req_chan.est_index)] <= req_chan.step_sq;
            end
         end
         // result staging, waits for a free output register
         if (pend_ff && out_free) begin
            pend_ff      <= 1'b0;
            rsp_valid_ff <= 1'b1;
            rsp_x_ff     <= yz_ff;
            rsp_e_ff     <= dy_ff;
            rsp_f_ff     <= fault_ff;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_READ: prev_ff <= prev_rd;
            S_DIV1: if (div_rsp.done) begin
               f1_ff    <= div_rsp.result;
               fault_ff <= fault_ff | div_rsp.fault;
            end
            S_DIV2: if (div_rsp.done) begin
               f2_ff    <= div_rsp.result;
               fault_ff <= fault_ff | div_rsp.fault;
            end
            S_DIFF: begin
               diff_ff  <= diff_s.value;
               fault_ff <= fault_ff | diff_s.ovf;
            end
            S_MUL1: if (mul_rsp.done) begin
               dy_ff    <= mul_rsp.result;
               fault_ff <= fault_ff | mul_rsp.fault;
            end
            S_MUL2: if (mul_rsp.done) begin
               c_ff     <= mul_rsp.result;
               fault_ff <= fault_ff | mul_rsp.fault;
            end
            S_NEXT: begin
               yz_ff    <= yz_s.value;
               fault_ff <= fault_ff | yz_s.ovf;
               k_ff     <= 3'(k_ff + 3'd1);
            end
            S_LAST: pend_ff <= 1'b1;
            S_IDLE: ;
            default: ;
         endcase
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.extrapolated   = rsp_x_ff;
   assign rsp_chan.error_estimate = rsp_e_ff;
   assign rsp_chan.fault          = rsp_f_ff;

endmodule
